/* rtl/sksl_pkg.sv */
// shared types, constants and key helpers for the sorted key set lookup
`default_nettype none
package sksl_pkg;

   localparam int MAX_KEYS  = 256;
   localparam int ADDR_W    = $clog2(MAX_KEYS);
   localparam int CNT_W     = $clog2(MAX_KEYS + 1);
   localparam int KEY_BYTES = 15;
   localparam int KEY_W     = 8 * KEY_BYTES;
   localparam int LEN_W     = 4;
   localparam int REQ_LEN_W = 7;
   localparam int ENTRY_W   = KEY_W + LEN_W;

   localparam logic [LEN_W-1:0] LEN_A_RESET = 4'd8;
   localparam logic [LEN_W-1:0] LEN_B_RESET = 4'd14;

   typedef enum logic [1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_BUILD  = 2'd2,
      REQ_QUERY  = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      STAT_ACCEPTED  = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_BUILT     = 3'd2,
      STAT_FOUND     = 3'd3,
      STAT_NOT_FOUND = 3'd4,
      STAT_EMPTY     = 3'd5,
      STAT_NOT_READY = 3'd6
   } status_type;

   typedef enum logic {
      CSR_LEN_A = 1'b0,
      CSR_LEN_B = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] len;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_B_INIT, ST_B_RDT, ST_B_WT, ST_B_RDP, ST_B_CMP, ST_B_PUT,
      ST_C_INIT, ST_C_RD, ST_C_CHK, ST_B_DONE, ST_Q_PROBE, ST_Q_CMP, ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_ACCEPT, CMD_EXEC, CMD_SORT_INIT, CMD_READ_T, CMD_TAKE_T,
      CMD_READ_PREV, CMD_SHIFT, CMD_PLACE, CMD_COMPACT_INIT, CMD_READ_E,
      CMD_CHECK_E, CMD_FINISH, CMD_PROBE, CMD_COMPARE, CMD_RESPOND
   } cmd_type;

   typedef struct packed {
      req_code_type op;
      logic         search_go;
      logic         few;
      logic         empty;
      logic         gt;
      logic         j_one;
      logic         i_last;
      logic         eq;
      logic         cont;
      logic         out_free;
   } dp_status_type;

   // key ends at its length, at KEY_BYTES or at its first zero byte
   function automatic entry_type canon_key(logic [KEY_W-1:0] raw,
                                           logic [REQ_LEN_W-1:0] length);
      entry_type  e;
      logic       keep;
      logic [7:0] b;
      e    = '0;
      keep = 1'b1;
      for (int i = 0; i < KEY_BYTES; i++) begin
         b    = raw[KEY_W-1-8*i -: 8];
         keep = keep && (REQ_LEN_W'(i) < length) && (b != 8'd0);
         if (keep) begin
            e.key[KEY_W-1-8*i -: 8] = b;
            e.len = LEN_W'(i + 1);
         end
      end
      return e;
   endfunction

endpackage
`default_nettype wire

/* rtl/sorted_key_set_lookup.sv */
// top level of the sorted key set lookup
`default_nettype none
// Keeps up to 256 text keys of up to 15 bytes in a single-port-write ram.
// Clear and insert go from accept through an execute state to respond. A
// query runs at most 9 binary search probes over 256 keys. A build runs an
// insertion sort then a dedup and length filter pass, both through the one
// ram read port with registered data: a key to sort is read and taken, each
// compare reads the key before it and shifts it if larger, then the key is
// placed; the filter reads and checks each key. A request is taken only while
// the controller is idle; a finished result waits in the output register
// while the next request is taken. No clearing pass after reset.
module sorted_key_set_lookup (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_type,
   input  wire logic [63:0]                    req_key_high,
   input  wire logic [55:0]                    req_key_low,
   input  wire logic [sksl_pkg::REQ_LEN_W-1:0] req_key_length,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [2:0]                          rsp_status,
   output logic [7:0]                          rsp_match_index,
   output logic [sksl_pkg::CNT_W-1:0]          rsp_list_count,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic                           csr_index,
   input  wire logic [sksl_pkg::LEN_W-1:0]     csr_data
);
   sksl_pkg::cmd_type       cmd;
   sksl_pkg::dp_status_type sts;

   assign csr_ready = 1'b1;

   sksl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sksl_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_type),
      .req_key_high    (req_key_high),
      .req_key_low     (req_key_low),
      .req_key_length  (req_key_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_match_index (rsp_match_index),
      .rsp_list_count  (rsp_list_count),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );
endmodule
`default_nettype wire

/* rtl/sksl_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module sksl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/sksl_ctrl.sv */
// control state machine sequencing clear, insert, build sort and query search
`default_nettype none
module sksl_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire sksl_pkg::dp_status_type sts,
   output sksl_pkg::cmd_type           cmd
);
   sksl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sksl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sksl_pkg::ST_IDLE: begin
            if (req_valid) state_in = sksl_pkg::ST_EXEC;
         end
         sksl_pkg::ST_EXEC: begin
            unique case (sts.op)
               sksl_pkg::REQ_BUILD: state_in = sksl_pkg::ST_B_INIT;
               sksl_pkg::REQ_QUERY:
                  state_in = sts.search_go ? sksl_pkg::ST_Q_PROBE : sksl_pkg::ST_RESP;
               default: state_in = sksl_pkg::ST_RESP;
            endcase
         end
         sksl_pkg::ST_B_INIT:
            state_in = sts.few ? sksl_pkg::ST_C_INIT : sksl_pkg::ST_B_RDT;
         sksl_pkg::ST_B_RDT:  state_in = sksl_pkg::ST_B_WT;
         sksl_pkg::ST_B_WT:   state_in = sksl_pkg::ST_B_RDP;
         sksl_pkg::ST_B_RDP:  state_in = sksl_pkg::ST_B_CMP;
         sksl_pkg::ST_B_CMP: begin
            if (sts.gt && !sts.j_one) state_in = sksl_pkg::ST_B_RDP;
            else                      state_in = sksl_pkg::ST_B_PUT;
         end
         sksl_pkg::ST_B_PUT:
            state_in = sts.i_last ? sksl_pkg::ST_C_INIT : sksl_pkg::ST_B_RDT;
         sksl_pkg::ST_C_INIT:
            state_in = sts.empty ? sksl_pkg::ST_B_DONE : sksl_pkg::ST_C_RD;
         sksl_pkg::ST_C_RD:   state_in = sksl_pkg::ST_C_CHK;
         sksl_pkg::ST_C_CHK:
            state_in = sts.i_last ? sksl_pkg::ST_B_DONE : sksl_pkg::ST_C_RD;
         sksl_pkg::ST_B_DONE: state_in = sksl_pkg::ST_RESP;
         sksl_pkg::ST_Q_PROBE: state_in = sksl_pkg::ST_Q_CMP;
         sksl_pkg::ST_Q_CMP: begin
            if (sts.eq || !sts.cont) state_in = sksl_pkg::ST_RESP;
            else                     state_in = sksl_pkg::ST_Q_PROBE;
         end
         sksl_pkg::ST_RESP: begin
            if (sts.out_free) state_in = sksl_pkg::ST_IDLE;
         end
         default: state_in = sksl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      cmd       = sksl_pkg::CMD_NONE;
      unique case (state_ff)
         sksl_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd = sksl_pkg::CMD_ACCEPT;
         end
         sksl_pkg::ST_EXEC:    cmd = sksl_pkg::CMD_EXEC;
         sksl_pkg::ST_B_INIT:  cmd = sksl_pkg::CMD_SORT_INIT;
         sksl_pkg::ST_B_RDT:   cmd = sksl_pkg::CMD_READ_T;
         sksl_pkg::ST_B_WT:    cmd = sksl_pkg::CMD_TAKE_T;
         sksl_pkg::ST_B_RDP:   cmd = sksl_pkg::CMD_READ_PREV;
         sksl_pkg::ST_B_CMP:   cmd = sksl_pkg::CMD_SHIFT;
         sksl_pkg::ST_B_PUT:   cmd = sksl_pkg::CMD_PLACE;
         sksl_pkg::ST_C_INIT:  cmd = sksl_pkg::CMD_COMPACT_INIT;
         sksl_pkg::ST_C_RD:    cmd = sksl_pkg::CMD_READ_E;
         sksl_pkg::ST_C_CHK:   cmd = sksl_pkg::CMD_CHECK_E;
         sksl_pkg::ST_B_DONE:  cmd = sksl_pkg::CMD_FINISH;
         sksl_pkg::ST_Q_PROBE: cmd = sksl_pkg::CMD_PROBE;
         sksl_pkg::ST_Q_CMP:   cmd = sksl_pkg::CMD_COMPARE;
         sksl_pkg::ST_RESP:    cmd = sksl_pkg::CMD_RESPOND;
         default:              cmd = sksl_pkg::CMD_NONE;
      endcase
   end
endmodule
`default_nettype wire

/* rtl/sksl_dp.sv */
// datapath: key store, counters, sort and search registers, result register
`default_nettype none
module sksl_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire sksl_pkg::cmd_type                cmd,
   output sksl_pkg::dp_status_type               sts,
   input  wire logic [1:0]                       req_type,
   input  wire logic [63:0]                      req_key_high,
   input  wire logic [55:0]                      req_key_low,
   input  wire logic [sksl_pkg::REQ_LEN_W-1:0]   req_key_length,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [2:0]                            rsp_status,
   output logic [7:0]                            rsp_match_index,
   output logic [sksl_pkg::CNT_W-1:0]            rsp_list_count,
   input  wire logic                             csr_valid,
   input  wire logic                             csr_index,
   input  wire logic [sksl_pkg::LEN_W-1:0]       csr_data
);
   localparam int AW = sksl_pkg::ADDR_W;
   localparam int CW = sksl_pkg::CNT_W;

   sksl_pkg::req_code_type op_ff, op_in;
   sksl_pkg::entry_type    q_ff, q_in, t_ff, t_in, prev_ff, prev_in;
   logic                   long_ff, long_in;
   logic [CW-1:0] stored_ff, stored_in, clean_ff, clean_in;
   logic          ready_ff, ready_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, n_ff, n_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [sksl_pkg::LEN_W-1:0] len_a_ff, len_a_in, len_b_ff, len_b_in;
   logic [2:0]    res_status_ff, res_status_in;
   logic [7:0]    res_index_ff, res_index_in;
   logic [CW-1:0] res_count_ff, res_count_in;
   logic          out_valid_ff, out_valid_in;
   logic [2:0]    out_status_ff, out_status_in;
   logic [7:0]    out_index_ff, out_index_in;
   logic [CW-1:0] out_count_ff, out_count_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   sksl_pkg::entry_type  wr_data, rd_data;
   logic [CW-1:0]        mid, lo_next, hi_next;
   logic                 keep, out_free;

   sksl_ram #(.WIDTH(sksl_pkg::ENTRY_W), .DEPTH(sksl_pkg::MAX_KEYS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !out_valid_ff || !rsp_stall;
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lo_next  = (rd_data.key < q_ff.key) ? mid_ff + CW'(1) : lo_ff;
   assign hi_next  = (rd_data.key < q_ff.key) ? hi_ff : mid_ff;
   // first of a run of equal keys, and length is one of the two kept
   assign keep     = ((i_ff == '0) || (rd_data.key != prev_ff.key)) &&
                     ((rd_data.len == len_a_ff) || (rd_data.len == len_b_ff));

   always_comb begin
      sts.op        = op_ff;
      sts.search_go = ready_ff && (clean_ff != '0) && !long_ff;
      sts.few       = stored_ff < CW'(2);
      sts.empty     = stored_ff == '0;
      sts.gt        = rd_data.key > t_ff.key;
      sts.j_one     = j_ff == CW'(1);
      sts.i_last    = ({1'b0, i_ff} + (CW+1)'(1)) >= {1'b0, stored_ff};
      sts.eq        = rd_data.key == q_ff.key;
      sts.cont      = lo_next < hi_next;
      sts.out_free  = out_free;
   end

   always_comb begin
      op_in = op_ff; q_in = q_ff; long_in = long_ff; t_in = t_ff; prev_in = prev_ff;
      stored_in = stored_ff; clean_in = clean_ff; ready_in = ready_ff;
      i_in = i_ff; j_in = j_ff; n_in = n_ff;
      lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff;
      res_status_in = res_status_ff; res_index_in = res_index_ff;
      res_count_in = res_count_ff;
      out_status_in = out_status_ff; out_index_in = out_index_ff;
      out_count_in = out_count_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      len_a_in = len_a_ff; len_b_in = len_b_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = q_ff; rd_addr = '0;

      if (csr_valid) begin
         unique case (sksl_pkg::csr_index_type'(csr_index))
            sksl_pkg::CSR_LEN_A: len_a_in = csr_data;
            sksl_pkg::CSR_LEN_B: len_b_in = csr_data;
            default: ;
         endcase
      end

      case (cmd)
         sksl_pkg::CMD_ACCEPT: begin
            op_in   = sksl_pkg::req_code_type'(req_type);
            q_in    = sksl_pkg::canon_key({req_key_high, req_key_low}, req_key_length);
            long_in = req_key_length > sksl_pkg::REQ_LEN_W'(sksl_pkg::KEY_BYTES);
         end
         sksl_pkg::CMD_EXEC: begin
            res_index_in = '0;
            unique case (op_ff)
               sksl_pkg::REQ_CLEAR: begin
                  stored_in = '0; clean_in = '0; ready_in = 1'b0;
                  res_status_in = sksl_pkg::STAT_ACCEPTED;
                  res_count_in  = '0;
               end
               sksl_pkg::REQ_INSERT: begin
                  res_count_in = stored_ff;
                  if (stored_ff >= CW'(sksl_pkg::MAX_KEYS)) begin
                     res_status_in = sksl_pkg::STAT_FULL;
                  end else begin
                     res_status_in = sksl_pkg::STAT_ACCEPTED;
                     if (!long_ff) begin
                        wr_en        = 1'b1;
                        wr_addr      = stored_ff[AW-1:0];
                        wr_data      = q_ff;
                        stored_in    = stored_ff + CW'(1);
                        ready_in     = 1'b0;
                        res_count_in = stored_ff + CW'(1);
                     end
                  end
               end
               sksl_pkg::REQ_QUERY: begin
                  lo_in = '0;
                  hi_in = clean_ff;
                  if (!ready_ff) begin
                     res_status_in = sksl_pkg::STAT_NOT_READY;
                     res_count_in  = '0;
                  end else if (clean_ff == '0) begin
                     res_status_in = sksl_pkg::STAT_EMPTY;
                     res_count_in  = '0;
                  end else begin
                     res_status_in = sksl_pkg::STAT_NOT_FOUND;
                     res_count_in  = clean_ff;
                  end
               end
               default: ;
            endcase
         end
         sksl_pkg::CMD_SORT_INIT: i_in = CW'(1);
         sksl_pkg::CMD_READ_T:    rd_addr = i_ff[AW-1:0];
         sksl_pkg::CMD_TAKE_T: begin
            t_in = rd_data;
            j_in = i_ff;
         end
         sksl_pkg::CMD_READ_PREV: rd_addr = AW'(j_ff - CW'(1));
         sksl_pkg::CMD_SHIFT: begin
            if (rd_data.key > t_ff.key) begin
               wr_en   = 1'b1;
               wr_addr = j_ff[AW-1:0];
               wr_data = rd_data;
               j_in    = j_ff - CW'(1);
            end
         end
         sksl_pkg::CMD_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[AW-1:0];
            wr_data = t_ff;
            i_in    = i_ff + CW'(1);
         end
         sksl_pkg::CMD_COMPACT_INIT: begin
            i_in = '0;
            n_in = '0;
         end
         sksl_pkg::CMD_READ_E: rd_addr = i_ff[AW-1:0];
         sksl_pkg::CMD_CHECK_E: begin
            if (keep) begin
               wr_en   = 1'b1;
               wr_addr = n_ff[AW-1:0];
               wr_data = rd_data;
               n_in    = n_ff + CW'(1);
            end
            prev_in = rd_data;
            i_in    = i_ff + CW'(1);
         end
         sksl_pkg::CMD_FINISH: begin
            stored_in     = n_ff;
            clean_in      = n_ff;
            ready_in      = 1'b1;
            res_status_in = sksl_pkg::STAT_BUILT;
            res_index_in  = '0;
            res_count_in  = n_ff;
         end
         sksl_pkg::CMD_PROBE: begin
            mid_in  = mid;
            rd_addr = mid[AW-1:0];
         end
         sksl_pkg::CMD_COMPARE: begin
            lo_in = lo_next;
            hi_in = hi_next;
            if (rd_data.key == q_ff.key) begin
               res_status_in = sksl_pkg::STAT_FOUND;
               res_index_in  = 8'(mid_ff);
            end
         end
         sksl_pkg::CMD_RESPOND: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_index_in  = res_index_ff;
               out_count_in  = res_count_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff    <= '0;
         clean_ff     <= '0;
         ready_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         len_a_ff     <= sksl_pkg::LEN_A_RESET;
         len_b_ff     <= sksl_pkg::LEN_B_RESET;
      end else begin
         stored_ff    <= stored_in;
         clean_ff     <= clean_in;
         ready_ff     <= ready_in;
         out_valid_ff <= out_valid_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; q_ff <= q_in; long_ff <= long_in; t_ff <= t_in; prev_ff <= prev_in;
      i_ff <= i_in; j_ff <= j_in; n_ff <= n_in;
      lo_ff <= lo_in; hi_ff <= hi_in; mid_ff <= mid_in;
      res_status_ff <= res_status_in; res_index_ff <= res_index_in;
      res_count_ff <= res_count_in;
      out_status_ff <= out_status_in; out_index_ff <= out_index_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_match_index = out_index_ff;
   assign rsp_list_count  = out_count_ff;
endmodule
`default_nettype wire
